// ===== hw/rtl/irs_pkg.sv =====
package irs_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int INDEX_WIDTH_DEF   = 32;

   localparam int CNT_W  = 5;
   localparam int SLOT_W = 4;
   localparam int OUT_W  = 32;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MAP  = 1'b1;

   // Table read address sources.
   localparam int RD_SEL_W = 3;
   localparam logic [RD_SEL_W-1:0] RD_LAST = 3'd0;
   localparam logic [RD_SEL_W-1:0] RD_ZERO = 3'd1;
   localparam logic [RD_SEL_W-1:0] RD_MID  = 3'd2;
   localparam logic [RD_SEL_W-1:0] RD_HIM1 = 3'd3;
   localparam logic [RD_SEL_W-1:0] RD_HI   = 3'd4;
   localparam logic [RD_SEL_W-1:0] RD_IDX  = 3'd5;

   typedef struct packed {
      logic                capture;
      logic                load_wr;
      logic                rd_en;
      logic [RD_SEL_W-1:0] rd_sel;
      logic                keep_last;
      logic                keep_prev;
      logic                set_nov;
      logic                first_from_rd;
      logic                idx_zero;
      logic                idx_last;
      logic                idx_hm1;
      logic                idx_hi;
      logic                search_init;
      logic                search_step;
      logic                walk_step;
      logic                walk_final;
      logic                emit;
      logic                emit_last;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic first_gt_brk;
      logic first_lt_res;
      logic end_lt_res;
      logic end_le_brk;
      logic first_gt_last;
      logic first_gt_prev;
      logic search_go;
      logic hi_zero;
      logic idx_at_end;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/irs_ctrl.sv =====
module irs_ctrl
   import irs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_op,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_LAST  = 4'd2;
   localparam logic [3:0] S_ZERO  = 4'd3;
   localparam logic [3:0] S_SRCH  = 4'd4;
   localparam logic [3:0] S_SCMP  = 4'd5;
   localparam logic [3:0] S_PREV  = 4'd6;
   localparam logic [3:0] S_HI    = 4'd7;
   localparam logic [3:0] S_WRD   = 4'd8;
   localparam logic [3:0] S_WEV   = 4'd9;
   localparam logic [3:0] S_FLUSH = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (st.empty) begin
               cmd.set_nov = 1'b1;
               state_in    = S_FLUSH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LAST;
               state_in   = S_LAST;
            end
         end
         S_LAST: begin
            cmd.keep_last = 1'b1;
            if (st.first_gt_brk) begin
               cmd.set_nov = 1'b1;
               state_in    = S_FLUSH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ZERO;
               state_in   = S_ZERO;
            end
         end
         S_ZERO: begin
            if (st.first_lt_res) begin
               if (st.end_lt_res) begin
                  cmd.set_nov = 1'b1;
                  state_in    = S_FLUSH;
               end else begin
                  cmd.first_from_rd = 1'b1;
                  cmd.idx_zero      = 1'b1;
                  state_in          = S_WRD;
               end
            end else if (st.first_gt_last) begin
               cmd.idx_last = 1'b1;
               state_in     = S_WRD;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_SRCH;
            end
         end
         S_SRCH: begin
            if (st.search_go) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_MID;
               state_in   = S_SCMP;
            end else if (st.hi_zero) begin
               // Single-entry table: entry zero is still in the read register.
               if (st.end_lt_res) begin
                  cmd.set_nov = 1'b1;
                  state_in    = S_FLUSH;
               end else begin
                  cmd.first_from_rd = 1'b1;
                  cmd.idx_zero      = 1'b1;
                  state_in          = S_WRD;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HIM1;
               state_in   = S_PREV;
            end
         end
         S_SCMP: begin
            cmd.search_step = 1'b1;
            state_in        = S_SRCH;
         end
         S_PREV: begin
            cmd.keep_prev = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_HI;
            state_in      = S_HI;
         end
         S_HI: begin
            if (st.end_lt_res && st.first_gt_prev) begin
               cmd.set_nov = 1'b1;
               state_in    = S_FLUSH;
            end else if (!st.first_gt_prev) begin
               cmd.idx_hm1 = 1'b1;
               state_in    = S_WRD;
            end else begin
               cmd.first_from_rd = 1'b1;
               cmd.idx_hi        = 1'b1;
               state_in          = S_WRD;
            end
         end
         S_WRD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_WEV;
         end
         S_WEV: begin
            if (st.end_lt_res) begin
               // The range ends before this interval: the held sub-range is the last.
               if (!st.pend_valid) begin
                  cmd.set_nov = 1'b1;
               end
               state_in = S_FLUSH;
            end else if (!st.pend_valid || st.out_free) begin
               // A held sub-range goes out now, since another one follows it.
               cmd.emit = st.pend_valid;
               if (st.end_le_brk) begin
                  cmd.walk_final = 1'b1;
                  state_in       = S_FLUSH;
               end else begin
                  cmd.walk_step = 1'b1;
                  state_in      = st.idx_at_end ? S_FLUSH : S_WRD;
               end
            end
         end
         S_FLUSH: begin
            if (st.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/irs_datapath.sv =====
module irs_datapath
   import irs_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic [CNT_W-1:0]       csr_interval_count,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [INDEX_WIDTH-1:0] req_resume_point,
   input  logic [INDEX_WIDTH-1:0] req_break_point,
   input  logic [INDEX_WIDTH-1:0] req_req_first,
   input  logic [INDEX_WIDTH-1:0] req_req_count,
   input  cmd_type                cmd,
   output status_type             st,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_sub_first,
   output logic [OUT_W-1:0]       rsp_sub_count,
   output logic                   rsp_is_last,
   output logic                   rsp_no_overlap
);

   localparam int IW    = INDEX_WIDTH;
   localparam int AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int SW    = $clog2(MAX_INTERVALS + 1);
   localparam int CMP_W = (SW > CNT_W) ? SW : CNT_W;
   localparam int SLC_W = (SW > SLOT_W) ? SW : SLOT_W;

   logic [IW-1:0] resume_mem [MAX_INTERVALS];
   logic [IW-1:0] break_mem  [MAX_INTERVALS];

   logic [CNT_W-1:0] count_ff;
   logic [SW-1:0]    size;
   logic [SW-1:0]    size_m1;

   logic [IW-1:0]    first_ff;
   logic [IW-1:0]    end_ff;
   logic             empty_ff;
   logic [IW-1:0]    rd_resume_ff;
   logic [IW-1:0]    rd_break_ff;
   logic [IW-1:0]    last_resume_ff;
   logic [IW-1:0]    prev_break_ff;
   logic [AW-1:0]    lo_ff;
   logic [AW-1:0]    hi_ff;
   logic [SW-1:0]    idx_ff;
   logic [IW-1:0]    pend_first_ff;
   logic [IW-1:0]    pend_count_ff;
   logic             pend_nov_ff;
   logic             pend_valid_ff;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_first_ff;
   logic [OUT_W-1:0] rsp_count_ff;
   logic             rsp_last_ff;
   logic             rsp_nov_ff;

   logic [IW:0]      end_sum;
   logic [IW-1:0]    end_in;
   logic [AW:0]      mid_sum;
   logic [AW-1:0]    mid;
   logic [AW-1:0]    hi_m1;
   logic [AW-1:0]    rd_addr;
   logic             slot_ok;
   logic [IW-1:0]    cur_first;
   logic             out_free;

   // Counts above the table depth act as a full table.
   assign size = (CMP_W'(count_ff) > CMP_W'(MAX_INTERVALS)) ? SW'(MAX_INTERVALS)
                                                           : SW'(count_ff);
   assign size_m1 = size - 1'b1;

   assign end_sum = {1'b0, req_req_first} + {1'b0, req_req_count} - (IW + 1)'(1);
   assign end_in  = end_sum[IW] ? '1 : end_sum[IW-1:0];

   assign mid_sum = (AW + 1)'(lo_ff) + (AW + 1)'(hi_ff);
   assign mid     = mid_sum[AW:1];
   assign hi_m1   = hi_ff - 1'b1;
   assign slot_ok = SLC_W'(req_slot) < SLC_W'(MAX_INTERVALS);

   // After the first walk step the cursor is the start of the current interval.
   assign cur_first = pend_valid_ff ? rd_resume_ff : first_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (cmd.rd_sel)
         RD_LAST: rd_addr = size_m1[AW-1:0];
         RD_ZERO: rd_addr = '0;
         RD_MID:  rd_addr = mid;
         RD_HIM1: rd_addr = hi_m1;
         RD_HI:   rd_addr = hi_ff;
         RD_IDX:  rd_addr = idx_ff[AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      st.empty         = empty_ff;
      st.first_gt_brk  = first_ff > rd_break_ff;
      st.first_lt_res  = first_ff < rd_resume_ff;
      st.end_lt_res    = end_ff < rd_resume_ff;
      st.end_le_brk    = end_ff <= rd_break_ff;
      st.first_gt_last = first_ff > last_resume_ff;
      st.first_gt_prev = first_ff > prev_break_ff;
      st.search_go     = ((AW + 1)'(hi_ff) - (AW + 1)'(lo_ff)) > (AW + 1)'(1);
      st.hi_zero       = (hi_ff == '0);
      st.idx_at_end    = ((SW + 1)'(idx_ff) + 1'b1) >= (SW + 1)'(size);
      st.pend_valid    = pend_valid_ff;
      st.out_free      = out_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && slot_ok) begin
         resume_mem[AW'(req_slot)] <= req_resume_point;
         break_mem[AW'(req_slot)]  <= req_break_point;
      end
      if (cmd.rd_en) begin
         rd_resume_ff <= resume_mem[rd_addr];
         rd_break_ff  <= break_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // The write channel is always ready.
         if (csr_valid) begin
            count_ff <= csr_interval_count;
         end
         if (cmd.capture) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.set_nov || cmd.walk_step || cmd.walk_final) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.emit && cmd.emit_last) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         first_ff <= req_req_first;
         end_ff   <= end_in;
         empty_ff <= (req_req_count == '0) || (size == '0);
      end else if (cmd.first_from_rd) begin
         first_ff <= rd_resume_ff;
      end
      if (cmd.keep_last) begin
         last_resume_ff <= rd_resume_ff;
      end
      if (cmd.keep_prev) begin
         prev_break_ff <= rd_break_ff;
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= size_m1[AW-1:0];
      end else if (cmd.search_step) begin
         if (first_ff > rd_resume_ff) begin
            lo_ff <= mid;
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.idx_zero) begin
         idx_ff <= '0;
      end else if (cmd.idx_last) begin
         idx_ff <= size_m1;
      end else if (cmd.idx_hm1) begin
         idx_ff <= SW'(hi_m1);
      end else if (cmd.idx_hi) begin
         idx_ff <= SW'(hi_ff);
      end else if (cmd.walk_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_first_ff <= OUT_W'(pend_first_ff);
         rsp_count_ff <= OUT_W'(pend_count_ff);
         rsp_last_ff  <= cmd.emit_last;
         rsp_nov_ff   <= pend_nov_ff;
      end
      if (cmd.set_nov) begin
         pend_first_ff <= '0;
         pend_count_ff <= '0;
         pend_nov_ff   <= 1'b1;
      end else if (cmd.walk_step) begin
         pend_first_ff <= cur_first;
         pend_count_ff <= rd_break_ff - cur_first + 1'b1;
         pend_nov_ff   <= 1'b0;
      end else if (cmd.walk_final) begin
         pend_first_ff <= cur_first;
         pend_count_ff <= end_ff - cur_first + 1'b1;
         pend_nov_ff   <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sub_first  = rsp_first_ff;
   assign rsp_sub_count  = rsp_count_ff;
   assign rsp_is_last    = rsp_last_ff;
   assign rsp_no_overlap = rsp_nov_ff;

endmodule

// ===== hw/rtl/interval_range_splitter.sv =====
// Maps a forward index range onto a sorted table of disjoint intervals and returns one
// clipped sub-range per overlapped interval, in ascending order, the last one marked;
// a request that touches nothing, or has a zero count, returns a single no-overlap beat.
// A load beat (op 0) writes one table slot and returns nothing. A map beat (op 1)
// blocks further beats until it is done, longer when the output stalls, because the
// table sits in one memory with a single registered read port: setup reads the last
// entry and entry zero before the binary search, each search step reads a midpoint
// and then compares, the entries at and below the search bound are read after it,
// and the walk reads one interval at a time, one read more than K result beats when
// the range ends short of an interval, before the final flush. The next beat is taken
// once the last result has been handed to the output register.
module interval_range_splitter
   import irs_pkg::*;
#(
   parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
   parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CNT_W-1:0]       csr_interval_count,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_op,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [INDEX_WIDTH-1:0] req_resume_point,
   input  logic [INDEX_WIDTH-1:0] req_break_point,
   input  logic [INDEX_WIDTH-1:0] req_req_first,
   input  logic [INDEX_WIDTH-1:0] req_req_count,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_sub_first,
   output logic [OUT_W-1:0]       rsp_sub_count,
   output logic                   rsp_is_last,
   output logic                   rsp_no_overlap
);

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   irs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   irs_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .INDEX_WIDTH   (INDEX_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_interval_count (csr_interval_count),
      .req_slot           (req_slot),
      .req_resume_point   (req_resume_point),
      .req_break_point    (req_break_point),
      .req_req_first      (req_req_first),
      .req_req_count      (req_req_count),
      .cmd                (cmd),
      .st                 (st),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sub_first      (rsp_sub_first),
      .rsp_sub_count      (rsp_sub_count),
      .rsp_is_last        (rsp_is_last),
      .rsp_no_overlap     (rsp_no_overlap)
   );

endmodule

// ===== tb/sv/splitter_checker.sv =====
`timescale 1ns / 100ps

module splitter_checker
   import irs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CNT_W-1:0]           csr_interval_count,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_op,
   input  logic [SLOT_W-1:0]          req_slot,
   input  logic [INDEX_WIDTH_DEF-1:0] req_resume_point,
   input  logic [INDEX_WIDTH_DEF-1:0] req_break_point,
   input  logic [INDEX_WIDTH_DEF-1:0] req_req_first,
   input  logic [INDEX_WIDTH_DEF-1:0] req_req_count,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [OUT_W-1:0]           rsp_sub_first,
   input  logic [OUT_W-1:0]           rsp_sub_count,
   input  logic                       rsp_is_last,
   input  logic                       rsp_no_overlap,
   output int                         mismatches,
   output int                         pending
);

   localparam int IW    = INDEX_WIDTH_DEF;
   localparam int MAX_N = MAX_INTERVALS_DEF;
   localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

   typedef struct packed {
      logic [OUT_W-1:0] first;
      logic [OUT_W-1:0] count;
      logic             last;
      logic             nov;
   } span_type;

   span_type        span_q [$];
   logic [IW-1:0]   resume_tab [MAX_N];
   logic [IW-1:0]   break_tab [MAX_N];
   logic [CNT_W-1:0] active_count;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic report(input string what, input logic [OUT_W-1:0] got,
                         input logic [OUT_W-1:0] want);
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic push_span(input logic [IW-1:0] f, input logic [IW-1:0] c,
                            input logic last, input logic nov);
      span_type s;
      s.first = f[OUT_W-1:0];
      s.count = c[OUT_W-1:0];
      s.last  = last;
      s.nov   = nov;
      span_q.push_back(s);
   endtask

   // Expected sub-ranges of one forward request against the current table.
   task automatic split_request(input logic [IW-1:0] q_first, input logic [IW-1:0] q_count);
      int            size, lo, hi, mid, idx, made;
      logic [IW-1:0] pos, stop;
      size = (active_count > MAX_N) ? MAX_N : int'(active_count);
      pos  = q_first;
      made = 0;
      if (q_count == '0 || size == 0) begin
         push_span('0, '0, 1'b1, 1'b1);
         return;
      end
      // The range end saturates at the top of the index space.
      if (q_count - 1'b1 > IDX_MAX - pos)
         stop = IDX_MAX;
      else
         stop = pos + q_count - 1'b1;
      if (pos > break_tab[size-1]) begin
         push_span('0, '0, 1'b1, 1'b1);
         return;
      end
      if (pos < resume_tab[0]) begin
         idx = 0;
         if (resume_tab[0] > stop) begin
            push_span('0, '0, 1'b1, 1'b1);
            return;
         end
         pos = resume_tab[0];
      end else if (pos > resume_tab[size-1]) begin
         idx = size - 1;
      end else begin
         lo = 0;
         hi = size - 1;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (pos > resume_tab[mid])
               lo = mid;
            else
               hi = mid;
         end
         idx = hi;
         if (idx == 0) begin
            if (resume_tab[0] > stop) begin
               push_span('0, '0, 1'b1, 1'b1);
               return;
            end
            pos = resume_tab[0];
         end else begin
            if (stop < resume_tab[idx] && pos > break_tab[idx-1]) begin
               push_span('0, '0, 1'b1, 1'b1);
               return;
            end
            if (pos <= break_tab[idx-1])
               idx--;
            else
               pos = resume_tab[idx];
         end
      end
      while (idx < size && stop >= resume_tab[idx]) begin
         if (stop <= break_tab[idx]) begin
            push_span(pos, stop - pos + 1'b1, 1'b0, 1'b0);
            made++;
            break;
         end
         push_span(pos, break_tab[idx] - pos + 1'b1, 1'b0, 1'b0);
         made++;
         idx++;
         if (idx >= size || stop < resume_tab[idx])
            break;
         pos = resume_tab[idx];
      end
      if (made == 0)
         push_span('0, '0, 1'b1, 1'b1);
      else
         span_q[span_q.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin : watch
      span_type want;
      if (reset) begin
         span_q.delete();
         active_count = '0;
         pending      = 0;
      end else begin
         if (csr_valid && csr_ready)
            active_count = csr_interval_count;
         // Retire the result beat before queuing new work taken at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (span_q.size() == 0) begin
               report("result beat with nothing expected", rsp_sub_first, '0);
            end else begin
               want = span_q.pop_front();
               if (rsp_sub_first !== want.first)
                  report("sub_first", rsp_sub_first, want.first);
               if (rsp_sub_count !== want.count)
                  report("sub_count", rsp_sub_count, want.count);
               if (rsp_is_last !== want.last)
                  report("is_last", OUT_W'(rsp_is_last), OUT_W'(want.last));
               if (rsp_no_overlap !== want.nov)
                  report("no_overlap", OUT_W'(rsp_no_overlap), OUT_W'(want.nov));
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == OP_LOAD) begin
               if (req_slot < MAX_N) begin
                  resume_tab[req_slot] = req_resume_point;
                  break_tab[req_slot]  = req_break_point;
               end
            end else begin
               split_request(req_req_first, req_req_count);
            end
         end
         pending = span_q.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import irs_pkg::*;

   localparam int IW          = INDEX_WIDTH_DEF;
   localparam int MAX_N       = MAX_INTERVALS_DEF;
   localparam int TOTAL_ITEMS = 410;
   localparam int SETTLE      = 80;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 2000000;

   typedef enum int {TBL_DENSE, TBL_WIDE, TBL_TOP, TBL_JUNK} table_style_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_valid;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_interval_count;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [SLOT_W-1:0]   req_slot;
   logic [IW-1:0]       req_resume_point;
   logic [IW-1:0]       req_break_point;
   logic [IW-1:0]       req_req_first;
   logic [IW-1:0]       req_req_count;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [OUT_W-1:0]    rsp_sub_first;
   logic [OUT_W-1:0]    rsp_sub_count;
   logic                rsp_is_last;
   logic                rsp_no_overlap;

   int                  mismatches;
   int                  pending;
   int                  items_sent;
   int                  size_now;
   int                  cycle_count;
   bit                  steady;
   bit                  hold_off;
   logic [IW-1:0]       shadow_res [MAX_N];
   logic [IW-1:0]       shadow_brk [MAX_N];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   interval_range_splitter dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_interval_count (csr_interval_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_slot           (req_slot),
      .req_resume_point   (req_resume_point),
      .req_break_point    (req_break_point),
      .req_req_first      (req_req_first),
      .req_req_count      (req_req_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sub_first      (rsp_sub_first),
      .rsp_sub_count      (rsp_sub_count),
      .rsp_is_last        (rsp_is_last),
      .rsp_no_overlap     (rsp_no_overlap)
   );

   splitter_checker span_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_interval_count (csr_interval_count),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_slot           (req_slot),
      .req_resume_point   (req_resume_point),
      .req_break_point    (req_break_point),
      .req_req_first      (req_req_first),
      .req_req_count      (req_req_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sub_first      (rsp_sub_first),
      .rsp_sub_count      (rsp_sub_count),
      .rsp_is_last        (rsp_is_last),
      .rsp_no_overlap     (rsp_no_overlap),
      .mismatches         (mismatches),
      .pending            (pending)
   );

   // Result side: random stalls, plus one long hold-off when asked for.
   initial begin : rsp_side
      int unsigned stall_left;
      bit          hold_seen;
      stall_left = 0;
      hold_seen  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off && !hold_seen)
            stall_left = HOLD_CYCLES;
         hold_seen = hold_off;
         if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                     : $urandom_range(1, 3);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 88)
         return $urandom_range(1, 3);
      else
         return $urandom_range(5, 40);
   endfunction

   task automatic send_beat(input logic op, input logic [SLOT_W-1:0] s,
                            input logic [IW-1:0] rp, input logic [IW-1:0] bp,
                            input logic [IW-1:0] f, input logic [IW-1:0] c);
      int gap;
      gap = steady ? 0 : sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op           <= op;
      req_slot         <= s;
      req_resume_point <= rp;
      req_break_point  <= bp;
      req_req_first    <= f;
      req_req_count    <= c;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic load_slot(input int s, input logic [IW-1:0] rp, input logic [IW-1:0] bp);
      shadow_res[s] = rp;
      shadow_brk[s] = bp;
      send_beat(OP_LOAD, SLOT_W'(s), rp, bp, $urandom, $urandom);
   endtask

   task automatic map_req(input logic [IW-1:0] f, input logic [IW-1:0] c);
      send_beat(OP_MAP, SLOT_W'($urandom), $urandom, $urandom, f, c);
   endtask

   // Wait until every expected beat is back, then let a trailing load finish.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_count(input logic [CNT_W-1:0] v);
      drain();
      csr_interval_count <= v;
      csr_valid          <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      size_now = (v > MAX_N) ? MAX_N : int'(v);
   endtask

   task automatic build_table(input table_style_type style);
      logic [IW-1:0] r [MAX_N];
      logic [IW-1:0] b [MAX_N];
      logic [IW-1:0] pos, gap, len, lift;
      int            order [MAX_N];
      int            k, j, tmp, shift;
      if (style == TBL_DENSE)
         pos = $urandom_range(0, 3);
      else if (style == TBL_WIDE)
         pos = $urandom & 32'h3FFF_FFFF;
      else
         pos = '0;
      for (k = 0; k < MAX_N; k++) begin
         if (style == TBL_DENSE) begin
            gap = (k == 0) ? '0 : $urandom_range(0, 6);
            len = $urandom_range(0, 5);
         end else begin
            shift = $urandom_range(0, 26);
            gap   = (k == 0) ? '0 : ($urandom & ((32'd1 << shift) - 1));
            shift = $urandom_range(0, 26);
            len   = $urandom & ((32'd1 << shift) - 1);
         end
         pos  = pos + gap;
         r[k] = pos;
         pos  = pos + len;
         b[k] = pos;
         pos  = pos + 1'b1;
      end
      if (style == TBL_TOP) begin
         // Shift the whole table up so the last interval ends on the largest index.
         lift = {IW{1'b1}} - b[MAX_N-1];
         for (k = 0; k < MAX_N; k++) begin
            r[k] = r[k] + lift;
            b[k] = b[k] + lift;
         end
      end else if (style == TBL_JUNK) begin
         for (k = 0; k < MAX_N; k++) begin
            r[k] = $urandom;
            b[k] = $urandom;
         end
      end
      for (k = 0; k < MAX_N; k++)
         order[k] = k;
      for (k = MAX_N - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      for (k = 0; k < MAX_N; k++)
         load_slot(order[k], r[order[k]], b[order[k]]);
   endtask

   // A request aimed at the table: often starts and ends near interval edges.
   task automatic pick_map(output logic [IW-1:0] f, output logic [IW-1:0] c);
      int            n, i, j;
      logic [IW-1:0] w;
      n = (size_now == 0) ? MAX_N : size_now;
      i = $urandom_range(0, n - 1);
      j = $urandom_range(i, n - 1);
      case ($urandom_range(0, 7))
         0: f = shadow_res[i];
         1: f = shadow_brk[i];
         2: f = shadow_res[i] - 1'b1;
         3: f = shadow_brk[i] + 1'b1;
         4, 5: begin
            w = shadow_brk[i] - shadow_res[i] + 1'b1;
            f = (w == '0) ? $urandom : shadow_res[i] + ($urandom % w);
         end
         6: f = $urandom;
         default: f = $urandom_range(0, 1) ? '0 : {IW{1'b1}};
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2: c = $urandom_range(1, 8);
         3: c = shadow_brk[j] - f + 1'b1;
         4: c = shadow_res[j] - f + 1'b1;
         5: c = shadow_brk[j] - f + 2'd2;
         6: c = shadow_res[j] - f;
         7: c = $urandom;
         8: c = $urandom_range(0, 1) ? {IW{1'b1}} : '0;
         default: c = $urandom & ((32'd1 << $urandom_range(0, 31)) - 1);
      endcase
   endtask

   initial begin : stimulus
      logic [IW-1:0]    f, c, rp, bp;
      logic [CNT_W-1:0] cnt;
      int               k, n, phase, plen, roll, s;
      reset              = 1'b1;
      csr_valid          = 1'b0;
      csr_interval_count = '0;
      req_valid          = 1'b0;
      req_op             = OP_LOAD;
      req_slot           = '0;
      req_resume_point   = '0;
      req_break_point    = '0;
      req_req_first      = '0;
      req_req_count      = '0;
      steady             = 1'b0;
      hold_off           = 1'b0;
      items_sent         = 0;
      size_now           = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Known table: a single-point interval, an adjacent pair, and a last
      // interval that stops one short of the largest index.
      for (k = 0; k < MAX_N; k++) begin
         rp = 100 + 20 * k;
         bp = rp + 9;
         if (k == 3)
            bp = rp;
         if (k == 5) begin
            rp = 190;
            bp = 199;
         end
         if (k == MAX_N - 1) begin
            rp = 32'hFFFF_FF00;
            bp = 32'hFFFF_FFFE;
         end
         load_slot(k, rp, bp);
      end
      write_count(5'd16);
      map_req(150, 0);
      map_req(10, 50);
      map_req(90, 15);
      map_req(0, 32'hFFFF_FFFF);
      map_req(32'hFFFF_FFFF, 1);
      map_req(32'hFFFF_FFF0, 32'h100);
      map_req(111, 5);
      map_req(160, 1);
      map_req(185, 10);
      map_req(105, 16);
      write_count(5'd31);
      map_req(0, 32'hFFFF_FFFF);
      write_count(5'd1);
      map_req(95, 100);
      write_count(5'd0);
      map_req(100, 5);

      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    build_table(TBL_DENSE);
            2:       build_table(TBL_WIDE);
            3:       build_table(TBL_TOP);
            4:       build_table(TBL_JUNK);
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:       cnt = 5'd0;
            1:       cnt = 5'd1;
            2:       cnt = $urandom_range(17, 31);
            3, 4:    cnt = $urandom_range(2, 15);
            default: cnt = 5'd16;
         endcase
         write_count(cnt);
         if (phase == 0) begin
            // Sender keeps offering beats while the result side holds off.
            steady   <= 1'b1;
            hold_off <= 1'b1;
            plen = 12;
         end else begin
            steady <= ($urandom_range(0, 4) == 0);
            plen = $urandom_range(25, 45);
         end
         for (n = 0; n < plen && items_sent < TOTAL_ITEMS; n++) begin
            roll = $urandom_range(0, 39);
            if (roll < 2) begin
               map_req($urandom, $urandom);
            end else if (roll == 2) begin
               load_slot($urandom_range(0, MAX_N - 1), $urandom, $urandom);
            end else if (roll == 3) begin
               // Reversed ends make a malformed interval.
               s = $urandom_range(0, MAX_N - 1);
               load_slot(s, shadow_brk[s], shadow_res[s]);
            end else begin
               pick_map(f, c);
               map_req(f, c);
            end
         end
         phase++;
      end

      drain();
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
